[design/bitmap_find_and_flip_allocator_macros.svh]
// assertion macros used by the bitmap allocator checker
// expects signals clk and arst_n in the scope of use
`ifndef BITMAP_FIND_AND_FLIP_ALLOCATOR_MACROS_SVH
`define BITMAP_FIND_AND_FLIP_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BFFA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bffa check failed");

// next-cycle implication, disabled during reset
`define BFFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bffa check failed");

`endif

[design/bffa_pkg.sv]
// shared constants, types and helper functions of the bitmap allocator
// no dependencies
package bffa_pkg;

	localparam int BITMAP_BITS = 256;
	localparam int WORD_BITS   = 32;
	localparam int NUM_WORDS   = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W      = $clog2(NUM_WORDS);
	localparam int BIT_W       = $clog2(WORD_BITS);

	// field widths fixed by the interface
	localparam int MODE_W = 3;
	localparam int POS_W  = 8;
	localparam int ACT_W  = 9;

	localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(256);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WIDX_W-1:0]    widx_t;
	typedef logic [BIT_W-1:0]     boff_t;

	typedef enum logic [MODE_W-1:0] {
		M_TEST       = 3'd0,
		M_FIRST_SET  = 3'd1,
		M_FIRST_ZERO = 3'd2,
		M_LAST_SET   = 3'd3,
		M_LAST_ZERO  = 3'd4
	} mode_t;

	// bitmap write port
	typedef struct packed {
		logic  en;
		widx_t addr;
		word_t data;
	} bm_wr_t;

	// result of one word scan
	typedef struct packed {
		logic  hit;
		boff_t off;
		word_t new_word;
	} scan_res_t;

	// lowest set bit of a nonzero word, binary search over halves
	function automatic boff_t lsb_pos(input word_t v);
		word_t m;
		word_t x;
		boff_t idx;
		x   = v;
		idx = '0;
		for (int lvl = BIT_W - 1; lvl >= 0; lvl--) begin
			m = {WORD_BITS{1'b1}} >> (WORD_BITS - (1 << lvl));
			if ((x & m) == '0) begin
				idx[lvl] = 1'b1;
				x = x >> (1 << lvl);
			end
		end
		return idx;
	endfunction

	// bit reversal of a word
	function automatic word_t rev_word(input word_t v);
		word_t r;
		for (int b = 0; b < WORD_BITS; b++) begin
			r[b] = v[WORD_BITS-1-b];
		end
		return r;
	endfunction

endpackage

[design/bffa_stream_if.sv]
// request and response channel interfaces of the bitmap allocator
// depends on bffa_pkg
interface bffa_req_if import bffa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [POS_W-1:0]  bit_index;

	modport source (output valid, output mode, output bit_index, input ready);
	modport sink (input valid, input mode, input bit_index, output ready);
endinterface

interface bffa_rsp_if import bffa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;
	logic             tested_value;

	modport source (output valid, output found, output position, output tested_value,
		input ready);
	modport sink (input valid, input found, input position, input tested_value,
		output ready);
endinterface

[design/bitmap_find_and_flip_allocator.sv]
// Bitmap allocator: test a bit, or find the first/last set/clear bit and flip it.
// A test or unused mode gives a registered result after the request beat; a find scans
// one word per cycle through the shared scan unit, up to NUM_WORDS words (8 here).
// One item at a time: a new request is taken only once the last result is committed.
// Reset: bitmap cleared and active_bits set to 256 at once, no clearing pass.
module bitmap_find_and_flip_allocator import bffa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [ACT_W-1:0] cfg_wdata,
	bffa_req_if.sink         req,
	bffa_rsp_if.source       rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t            state_q;
	logic [ACT_W-1:0]  active_bits_q;
	logic [MODE_W-1:0] mode_q;
	logic [POS_W-1:0]  idx_q;
	logic [ACT_W-1:0]  limit_q;
	widx_t             last_w_q;
	widx_t             w_q;
	logic              upward_q;
	logic              want_q;

	logic              rsp_valid_q;
	logic              found_q;
	logic [POS_W-1:0]  position_q;
	logic              tested_q;

	logic [ACT_W-1:0]  lim_d;
	logic [ACT_W-1:0]  lim_m1;
	widx_t             last_d;
	logic              upward_d;
	logic              accept;
	logic              is_test;
	logic              is_find;
	logic              empty;
	logic [BIT_W:0]    rem;
	word_t             mask;
	widx_t             end_w;
	widx_t             rd_addr;
	word_t             rd_data;
	scan_res_t         scan;
	logic              fin;
	logic              slot_free;
	logic              commit;
	logic              hit_ok;
	bm_wr_t            wr;

	// request decode
	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign lim_d    = (active_bits_q > ACT_W'(BITMAP_BITS)) ? ACT_W'(BITMAP_BITS)
		: active_bits_q;
	assign lim_m1   = lim_d - ACT_W'(1);
	assign last_d   = lim_m1[BIT_W +: WIDX_W];
	assign upward_d = (req.mode == M_FIRST_SET) || (req.mode == M_FIRST_ZERO);

	// scan controls
	assign is_test = (mode_q == M_TEST);
	always_comb begin
		case (mode_q)
			M_FIRST_SET, M_FIRST_ZERO, M_LAST_SET, M_LAST_ZERO: is_find = 1'b1;
			default: is_find = 1'b0;
		endcase
	end
	assign empty   = (limit_q == '0);
	assign rd_addr = is_test ? idx_q[BIT_W +: WIDX_W] : w_q;
	assign end_w   = upward_q ? last_w_q : '0;

	// active mask, partial only in the last active word
	assign rem = (limit_q[BIT_W-1:0] == '0) ? (BIT_W+1)'(WORD_BITS)
		: {1'b0, limit_q[BIT_W-1:0]};
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mask[b] = (w_q != last_w_q) || ((BIT_W+1)'(b) < rem);
		end
	end

	bffa_bitmap u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

	bffa_scan_unit u_scan (
		.word   (rd_data),
		.mask   (mask),
		.want   (want_q),
		.upward (upward_q),
		.res    (scan)
	);

	// completion and commit
	assign hit_ok    = is_find && !empty && scan.hit;
	assign fin       = !is_find || empty || scan.hit || (w_q == end_w);
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign commit    = (state_q == S_SCAN) && fin && slot_free;

	always_comb begin
		wr.en   = commit && hit_ok;
		wr.addr = w_q;
		wr.data = scan.new_word;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_SCAN;
				S_SCAN: if (commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item registers and word pointer
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= req.mode;
			idx_q    <= req.bit_index;
			limit_q  <= lim_d;
			last_w_q <= last_d;
			upward_q <= upward_d;
			want_q   <= (req.mode == M_FIRST_SET) || (req.mode == M_LAST_SET);
			w_q      <= upward_d ? widx_t'(0) : last_d;
		end else if ((state_q == S_SCAN) && !fin) begin
			w_q <= upward_q ? w_q + widx_t'(1) : w_q - widx_t'(1);
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bits_q <= ACT_RESET;
		end else if (cfg_we) begin
			active_bits_q <= cfg_wdata;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			found_q    <= hit_ok;
			position_q <= hit_ok ? POS_W'({w_q, scan.off}) : '0;
			tested_q   <= is_test ? rd_data[idx_q[BIT_W-1:0]] : 1'b0;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.found        = found_q;
	assign rsp.position     = position_q;
	assign rsp.tested_value = tested_q;

endmodule

[design/bffa_bitmap.sv]
// bitmap word store, one combinational read port and one write port
// depends on bffa_pkg
module bffa_bitmap import bffa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  widx_t  rd_addr,
	output word_t  rd_data,
	input  bm_wr_t wr
);

	word_t words_q [NUM_WORDS];

	// word storage, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				words_q[i] <= '0;
			end
		end else if (wr.en) begin
			words_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = words_q[rd_addr];

endmodule

[design/bffa_scan_unit.sv]
// shared word scanner: finds the lowest or highest qualifying bit of one word
// depends on bffa_pkg
module bffa_scan_unit import bffa_pkg::*; (
	input  word_t     word,
	input  word_t     mask,
	input  logic      want,
	input  logic      upward,
	output scan_res_t res
);

	word_t cand;
	boff_t lo_off;
	boff_t hi_off;

	// candidates are bits equal to the wanted value inside the active mask
	assign cand   = (want ? word : ~word) & mask;
	assign lo_off = lsb_pos(cand);
	assign hi_off = BIT_W'(WORD_BITS - 1) - lsb_pos(rev_word(cand));

	// flip the chosen bit
	always_comb begin
		res.hit      = (cand != '0);
		res.off      = upward ? lo_off : hi_off;
		res.new_word = word ^ (word_t'(1) << res.off);
	end

endmodule

[design/bffa_checker.sv]
// port-level checks of the bitmap allocator, bound to the top level
// depends on bffa_pkg and the assertion macro header
`include "bitmap_find_and_flip_allocator_macros.svh"

module bffa_checker import bffa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic             found,
	input logic [POS_W-1:0] position,
	input logic             tested_value
);

	// one item at a time: busy right after a request beat
	`BFFA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

	// a stalled response holds its payload
	`BFFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(found) && $stable(position) && $stable(tested_value))

	// not found reports position zero
	`BFFA_ASSERT_NOW(a_pos_zero, rsp_valid && !found, position == '0)

	// a find never reports a tested value
	`BFFA_ASSERT_NOW(a_find_no_test, rsp_valid && found, !tested_value)

endmodule

bind bitmap_find_and_flip_allocator bffa_checker u_bffa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.found        (rsp.found),
	.position     (rsp.position),
	.tested_value (rsp.tested_value)
);

[verif/bitmap_find_and_flip_allocator_tb.sv]
// self-checking testbench of the bitmap find-and-flip allocator
// depends on bffa_pkg, the bffa_req_if / bffa_rsp_if interfaces and the allocator rtl
module bitmap_find_and_flip_allocator_tb;
	import bffa_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 6;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 12;
	localparam logic [MODE_W-1:0] MODE_RSVD_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD_LAST = 3'd7;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             tested_value;
	} alloc_result_t;

	// shadow copy of the bitmap plus the queue of results still owed
	class bitmap_shadow;
		bit [BITMAP_BITS-1:0] bitmap;
		bit [ACT_W-1:0]       active_cnt;
		alloc_result_t        pending_results[$];
		int                   errors;

		function new();
			bitmap = '0;
			active_cnt = ACT_RESET;
			errors = 0;
		endfunction

		function void set_active(input logic [ACT_W-1:0] v);
			active_cnt = v;
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction

		// apply one request beat and queue the result it must produce
		function void note_request(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] idx);
			alloc_result_t r;
			int            lim;
			int            p;
			bit            want;
			bit            upward;
			r = '0;
			lim = (active_cnt > BITMAP_BITS) ? BITMAP_BITS : int'(active_cnt);
			case (m)
				M_TEST: r.tested_value = bitmap[idx];
				M_FIRST_SET, M_FIRST_ZERO, M_LAST_SET, M_LAST_ZERO: begin
					want = (m == M_FIRST_SET || m == M_LAST_SET);
					upward = (m == M_FIRST_SET || m == M_FIRST_ZERO);
					for (int k = 0; k < lim && !r.found; k++) begin
						p = upward ? k : lim - 1 - k;
						if (bitmap[p] == want) begin
							bitmap[p] = !want;
							r.found = 1'b1;
							r.position = p[POS_W-1:0];
						end
					end
				end
				default: ;
			endcase
			pending_results.push_back(r);
		endfunction

		// compare one response beat against the oldest owed result
		function void check_result(input logic f, input logic [POS_W-1:0] pos, input logic tv);
			alloc_result_t exp_r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response beat found=%0b position=%0d tested_value=%0b",
					$time, f, pos, tv);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (f !== exp_r.found) begin
				$display("%0t: found mismatch expected %0b actual %0b", $time, exp_r.found, f);
				errors++;
			end
			if (pos !== exp_r.position) begin
				$display("%0t: position mismatch expected %0d actual %0d", $time,
					exp_r.position, pos);
				errors++;
			end
			if (tv !== exp_r.tested_value) begin
				$display("%0t: tested_value mismatch expected %0b actual %0b", $time,
					exp_r.tested_value, tv);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [ACT_W-1:0] cfg_wdata;

	bffa_req_if req_ch();
	bffa_rsp_if rsp_ch();

	bitmap_shadow shadow;
	int           burst_left;
	int           idle_cycles;
	int           rx_style;
	int           rx_left;

	bitmap_find_and_flip_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// receiver: switches between always ready, random stalls and a periodic stall
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = $urandom_range(0, 2);
			rx_left = $urandom_range(20, 80);
		end else begin
			rx_left--;
		end
		case (rx_style)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			default: rsp_ch.ready <= ((rx_left % 8) < 3);
		endcase
	end

	// observe config writes and both channels at the sampling edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				shadow.set_active(cfg_wdata);
			if (req_ch.valid && req_ch.ready)
				shadow.note_request(req_ch.mode, req_ch.bit_index);
			if (rsp_ch.valid && rsp_ch.ready)
				shadow.check_result(rsp_ch.found, rsp_ch.position, rsp_ch.tested_value);
		end
	end

	// watchdog on cycles with no beat of any kind
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// one request beat, then a random gap at the end of a burst
	task automatic issue(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] idx);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.bit_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// stop sending and wait for every owed result
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (shadow.pending_count() != 0) @(negedge clk);
	endtask

	task automatic reconfigure(input logic [ACT_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly finds, tilted toward setting or clearing by set_pct
	function automatic logic [MODE_W-1:0] pick_mode(input int set_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return M_TEST;
		if (r < 15)
			return MODE_RSVD_FIRST + MODE_W'($urandom_range(0, MODE_RSVD_LAST - MODE_RSVD_FIRST));
		if ($urandom_range(0, 99) < set_pct)
			return $urandom_range(0, 1) ? M_FIRST_ZERO : M_LAST_ZERO;
		return $urandom_range(0, 1) ? M_FIRST_SET : M_LAST_SET;
	endfunction

	task automatic run_random(input int count, input int set_pct);
		for (int n = 0; n < count; n++)
			issue(pick_mode(set_pct), POS_W'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [ACT_W-1:0] phase_cfg[10];
		int               phase_pct[10];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = M_TEST;
		req_ch.bit_index = '0;
		rsp_ch.ready = 1'b0;
		burst_left = 1;
		idle_cycles = 0;
		rx_style = 0;
		rx_left = 0;
		shadow = new();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty map at full width
		issue(M_TEST, 8'd0);
		issue(M_TEST, 8'd255);
		issue(M_FIRST_SET, 8'd0);
		issue(M_LAST_SET, 8'd255);
		issue(M_FIRST_ZERO, 8'd0);
		issue(M_LAST_ZERO, 8'd0);
		issue(M_TEST, 8'd0);
		issue(M_TEST, 8'd255);
		issue(M_FIRST_ZERO, 8'd255);
		issue(M_LAST_ZERO, 8'd170);
		issue(MODE_RSVD_FIRST, 8'd1);
		issue(MODE_RSVD_FIRST + 3'd1, 8'd85);
		issue(MODE_RSVD_LAST, 8'd255);
		issue(M_FIRST_SET, 8'd0);
		issue(M_LAST_SET, 8'd0);
		issue(M_TEST, 8'd128);

		// no active bits: searches find nothing, test still reads the map
		reconfigure(9'd0);
		issue(M_FIRST_SET, 8'd0);
		issue(M_LAST_SET, 8'd0);
		issue(M_FIRST_ZERO, 8'd0);
		issue(M_LAST_ZERO, 8'd0);
		issue(M_TEST, 8'd254);

		// count above the map size acts as the full map
		reconfigure(9'd511);
		issue(M_LAST_ZERO, 8'd0);
		issue(M_LAST_SET, 8'd0);

		// single active bit: second set finds nothing
		reconfigure(9'd1);
		issue(M_FIRST_ZERO, 8'd0);
		issue(M_LAST_ZERO, 8'd0);
		issue(M_TEST, 8'd1);

		// random phases over a spread of active counts, each tilted toward fill or drain by its own pct
		phase_cfg = '{9'd1, 9'd32, 9'd256, 9'd0, 9'd511, 9'd257, 9'd5, 9'd33, 9'd255, 9'd256};
		phase_pct = '{70, 85, 80, 50, 20, 60, 50, 90, 15, 50};
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 6)
				reconfigure(ACT_W'($urandom_range(2, 256)));
			else
				reconfigure(phase_cfg[ph]);
			run_random($urandom_range(40, 52), phase_pct[ph]);
		end

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (shadow.errors == 0 && shadow.pending_count() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/bffa_pkg.sv
design/bffa_stream_if.sv
design/bffa_bitmap.sv
design/bffa_scan_unit.sv
design/bitmap_find_and_flip_allocator.sv
design/bffa_checker.sv
verif/bitmap_find_and_flip_allocator_tb.sv
